// File: rtl/ffea_pkg.sv
package ffea_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int BLOCK_BYTES = 4096;
    localparam int BB_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int TOTAL_RESET = 131072;
    localparam int TOTAL_MAX   = 1048576;
    localparam int TOT_W       = 21;
    localparam int START_W     = 20;
    localparam int SLOTF_W     = 6;
    localparam int BYTES_W     = 32;
    localparam int STATUS_W    = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_SPACE,
        ST_NO_SLOT,
        ST_NO_RUN,
        ST_SLOT_UNUSED
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_CHK,
        S_SCAN,
        S_SCAN_TAIL,
        S_PASS_END,
        S_FREE_RD,
        S_FREE_WB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    scan_start;
        logic    scan_issue;
        logic    pass_restart;
        logic    rd_slot;
        logic    commit_alloc;
        logic    commit_free;
        logic    set_error;
        status_t err_code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic no_space;
        logic last_idx;
        logic moved;
        logic fit_ok;
        logic pass0;
        logic have_free;
        logic free_ok;
    } stat_t;

endpackage

// File: rtl/ffea_in_if.sv
interface ffea_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [ffea_pkg::BYTES_W-1:0]    request_bytes;
    logic [ffea_pkg::SLOTF_W-1:0]    slot;

    modport source (output valid, output operation, output request_bytes, output slot,
                    input ready);
    modport sink (input valid, input operation, input request_bytes, input slot,
                  output ready);
endinterface

// File: rtl/ffea_out_if.sv
interface ffea_out_if;
    logic                             valid;
    logic                             ready;
    logic [ffea_pkg::STATUS_W-1:0]    status;
    logic [ffea_pkg::SLOTF_W-1:0]     slot_index;
    logic [ffea_pkg::START_W-1:0]     extent_base;
    logic [ffea_pkg::TOT_W-1:0]       extent_len;
    logic [ffea_pkg::TOT_W-1:0]       free_count;

    modport source (output valid, output status, output slot_index, output extent_base,
                    output extent_len, output free_count, input ready);
    modport sink (input valid, input status, input slot_index, input extent_base,
                  input extent_len, input free_count, output ready);
endinterface

// File: rtl/ffea_ctrl.sv
module ffea_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_operation,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  ffea_pkg::stat_t   stat,
    output ffea_pkg::cmd_t    cmd
);

    ffea_pkg::state_t state_reg;
    ffea_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffea_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.err_code = ffea_pkg::ST_OK;
        in_ready     = 1'b0;
        unique case (state_reg)
            ffea_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = in_operation ? ffea_pkg::S_FREE_RD : ffea_pkg::S_ALLOC_CHK;
                end
            end
            ffea_pkg::S_ALLOC_CHK:
            begin
                if (stat.no_space)
                begin
                    cmd.set_error = 1'b1;
                    cmd.err_code  = ffea_pkg::ST_NO_SPACE;
                    state_next    = ffea_pkg::S_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ffea_pkg::S_SCAN;
                end
            end
            ffea_pkg::S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.last_idx)
                    state_next = ffea_pkg::S_SCAN_TAIL;
            end
            ffea_pkg::S_SCAN_TAIL:
            begin
                state_next = ffea_pkg::S_PASS_END;
            end
            ffea_pkg::S_PASS_END:
            begin
                if (stat.pass0 && !stat.have_free)
                begin
                    cmd.set_error = 1'b1;
                    cmd.err_code  = ffea_pkg::ST_NO_SLOT;
                    state_next    = ffea_pkg::S_DONE;
                end
                else if (!stat.fit_ok)
                begin
                    cmd.set_error = 1'b1;
                    cmd.err_code  = ffea_pkg::ST_NO_RUN;
                    state_next    = ffea_pkg::S_DONE;
                end
                else if (stat.moved)
                begin
                    cmd.pass_restart = 1'b1;
                    state_next       = ffea_pkg::S_SCAN;
                end
                else
                begin
                    cmd.commit_alloc = 1'b1;
                    state_next       = ffea_pkg::S_DONE;
                end
            end
            ffea_pkg::S_FREE_RD:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = ffea_pkg::S_FREE_WB;
            end
            ffea_pkg::S_FREE_WB:
            begin
                if (stat.free_ok)
                    cmd.commit_free = 1'b1;
                else
                begin
                    cmd.set_error = 1'b1;
                    cmd.err_code  = ffea_pkg::ST_SLOT_UNUSED;
                end
                state_next = ffea_pkg::S_DONE;
            end
            ffea_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ffea_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffea_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/ffea_dp.sv
module ffea_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ffea_pkg::TOT_W-1:0]        cfg_wdata,
    input  logic [ffea_pkg::BYTES_W-1:0]      in_request_bytes,
    input  logic [ffea_pkg::SLOTF_W-1:0]      in_slot,
    input  ffea_pkg::cmd_t                    cmd,
    output ffea_pkg::stat_t                   stat,
    output logic [ffea_pkg::STATUS_W-1:0]     out_status,
    output logic [ffea_pkg::SLOTF_W-1:0]      out_slot_index,
    output logic [ffea_pkg::START_W-1:0]      out_ext_base,
    output logic [ffea_pkg::TOT_W-1:0]        out_ext_len,
    output logic [ffea_pkg::TOT_W-1:0]        out_free_count
);

    localparam int TW = ffea_pkg::TOT_W;
    localparam int SW = ffea_pkg::SLOT_W;
    localparam int QW = ffea_pkg::BYTES_W + 1;

    logic [ffea_pkg::START_W-1:0] start_mem [ffea_pkg::SLOTS];
    logic [TW-1:0]                len_mem   [ffea_pkg::SLOTS];
    logic [TW-1:0]                end_mem   [ffea_pkg::SLOTS];
    logic [ffea_pkg::SLOTS-1:0]   used_reg;

    logic [TW-1:0]                total_reg;
    logic [TW-1:0]                free_reg;
    logic [TW-1:0]                need_reg;
    logic [ffea_pkg::SLOTF_W-1:0] slot_reg;
    logic                         slot_ok_reg;
    logic [TW-1:0]                cand_reg;
    logic [SW-1:0]                idx_reg;
    logic [SW-1:0]                ff_idx_reg;
    logic                         ff_found_reg;
    logic                         moved_reg;
    logic                         pass0_reg;
    logic                         rd_scan_reg;
    logic                         rd_used_reg;
    logic [ffea_pkg::START_W-1:0] rd_start_reg;
    logic [TW-1:0]                rd_len_reg;
    logic [TW-1:0]                rd_end_reg;

    logic [ffea_pkg::STATUS_W-1:0] res_status_reg;
    logic [ffea_pkg::SLOTF_W-1:0]  res_slot_reg;
    logic [ffea_pkg::START_W-1:0]  res_start_reg;
    logic [TW-1:0]                 res_count_reg;

    logic [ffea_pkg::STATUS_W-1:0] out_status_reg;
    logic [ffea_pkg::SLOTF_W-1:0]  out_slot_reg;
    logic [ffea_pkg::START_W-1:0]  out_start_reg;
    logic [TW-1:0]                 out_count_reg;
    logic [TW-1:0]                 out_free_reg;

    logic [QW-1:0] quot;
    logic [TW-1:0] need_in;
    logic [TW-1:0] cfg_val;
    logic [SW-1:0] slot_addr;
    logic [SW-1:0] rd_addr;
    logic [TW:0]   cand_end;
    logic [TW:0]   free_sum;
    logic [TW-1:0] free_sat;
    logic          overlap;

    // ceiling of bytes over block size, floor of one, capped just above the max
    always_comb
    begin
        quot = QW'(in_request_bytes >> ffea_pkg::BB_SHIFT)
             + QW'(|in_request_bytes[ffea_pkg::BB_SHIFT-1:0]);
        if (quot == '0)
            need_in = TW'(1);
        else if (quot > QW'(ffea_pkg::TOTAL_MAX))
            need_in = TW'(ffea_pkg::TOTAL_MAX + 1);
        else
            need_in = TW'(quot);
    end

    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_val = TW'(1);
        else if (cfg_wdata > TW'(ffea_pkg::TOTAL_MAX))
            cfg_val = TW'(ffea_pkg::TOTAL_MAX);
        else
            cfg_val = cfg_wdata;
    end

    assign slot_addr = SW'(slot_reg);
    assign rd_addr   = cmd.rd_slot ? slot_addr : idx_reg;
    assign cand_end  = {1'b0, cand_reg} + {1'b0, need_reg};
    assign overlap   = rd_used_reg && ({1'b0, rd_start_reg} < cand_end)
                       && (rd_end_reg > cand_reg);
    assign free_sum  = {1'b0, free_reg} + {1'b0, rd_len_reg};
    assign free_sat  = (free_sum > {1'b0, total_reg}) ? total_reg : TW'(free_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue || cmd.rd_slot)
        begin
            rd_start_reg <= start_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
        if (cmd.commit_alloc)
        begin
            start_mem[ff_idx_reg] <= cand_reg[ffea_pkg::START_W-1:0];
            len_mem[ff_idx_reg]   <= need_reg;
            end_mem[ff_idx_reg]   <= TW'(cand_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            total_reg    <= TW'(ffea_pkg::TOTAL_RESET);
            free_reg     <= TW'(ffea_pkg::TOTAL_RESET);
            rd_scan_reg  <= 1'b0;
            idx_reg      <= '0;
            moved_reg    <= 1'b0;
            pass0_reg    <= 1'b0;
            ff_found_reg <= 1'b0;
        end
        else
        begin
            rd_scan_reg <= cmd.scan_issue;
            if (cfg_we)
            begin
                total_reg <= cfg_val;
                free_reg  <= cfg_val;
            end
            if (cmd.scan_start)
            begin
                idx_reg      <= '0;
                moved_reg    <= 1'b0;
                pass0_reg    <= 1'b1;
                ff_found_reg <= 1'b0;
            end
            if (cmd.pass_restart)
            begin
                idx_reg   <= '0;
                moved_reg <= 1'b0;
                pass0_reg <= 1'b0;
            end
            if (cmd.scan_issue)
                idx_reg <= idx_reg + SW'(1);
            if (rd_scan_reg)
            begin
                if (overlap)
                    moved_reg <= 1'b1;
                if (pass0_reg && !rd_used_reg && !ff_found_reg)
                    ff_found_reg <= 1'b1;
            end
            if (cmd.commit_alloc)
            begin
                used_reg[ff_idx_reg] <= 1'b1;
                free_reg             <= free_reg - need_reg;
            end
            if (cmd.commit_free)
            begin
                used_reg[slot_addr] <= 1'b0;
                free_reg            <= free_sat;
            end
        end
    end

    logic [SW-1:0] rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            need_reg    <= need_in;
            slot_reg    <= in_slot;
            slot_ok_reg <= (int'(in_slot) < ffea_pkg::SLOTS);
        end
        // candidate keeps its value across passes
        if (cmd.scan_start)
            cand_reg <= '0;
        if (cmd.scan_issue || cmd.rd_slot)
        begin
            rd_used_reg <= used_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
        if (rd_scan_reg)
        begin
            if (overlap)
                cand_reg <= rd_end_reg;
            if (pass0_reg && !rd_used_reg && !ff_found_reg)
                ff_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit_alloc)
        begin
            res_status_reg <= ffea_pkg::ST_OK;
            res_slot_reg   <= ffea_pkg::SLOTF_W'(ff_idx_reg);
            res_start_reg  <= cand_reg[ffea_pkg::START_W-1:0];
            res_count_reg  <= need_reg;
        end
        if (cmd.commit_free)
        begin
            res_status_reg <= ffea_pkg::ST_OK;
            res_slot_reg   <= slot_reg;
            res_start_reg  <= rd_start_reg;
            res_count_reg  <= rd_len_reg;
        end
        if (cmd.set_error)
        begin
            res_status_reg <= cmd.err_code;
            res_slot_reg   <= (cmd.err_code == ffea_pkg::ST_SLOT_UNUSED) ? slot_reg : '0;
            res_start_reg  <= '0;
            res_count_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_start_reg  <= res_start_reg;
            out_count_reg  <= res_count_reg;
            out_free_reg   <= free_reg;
        end
    end

    always_comb
    begin
        stat.no_space  = need_reg > free_reg;
        stat.last_idx  = idx_reg == SW'(ffea_pkg::SLOTS - 1);
        stat.moved     = moved_reg;
        stat.fit_ok    = cand_end <= {1'b0, total_reg};
        stat.pass0     = pass0_reg;
        stat.have_free = ff_found_reg;
        stat.free_ok   = slot_ok_reg && rd_used_reg;
    end

    assign out_status     = out_status_reg;
    assign out_slot_index = out_slot_reg;
    assign out_ext_base   = out_start_reg;
    assign out_ext_len    = out_count_reg;
    assign out_free_count = out_free_reg;

endmodule

// File: rtl/first_fit_extent_allocator_core.sv
// First-fit extent allocator: keeps SLOTS extent slots over a managed area whose
// size in blocks is set through the configuration port, and answers each request
// item with one result item.
// An allocate makes P passes over the extent table: 0 when free blocks run
// short, else 1 to SLOTS + 1. The table memory is read one entry per cycle and
// the candidate start moves past each overlapping extent until a pass is clean.
// Output stalls hold a result until it is taken.
// A new request is taken while the previous result waits on the output.
module first_fit_extent_allocator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffea_pkg::TOT_W-1:0]    cfg_wdata,
    ffea_in_if.sink                       req,
    ffea_out_if.source                    rsp
);

    ffea_pkg::cmd_t  cmd;
    ffea_pkg::stat_t stat;

    ffea_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .in_ready     (req.ready),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    ffea_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_request_bytes (req.request_bytes),
        .in_slot          (req.slot),
        .cmd              (cmd),
        .stat             (stat),
        .out_status       (rsp.status),
        .out_slot_index   (rsp.slot_index),
        .out_ext_base     (rsp.extent_base),
        .out_ext_len      (rsp.extent_len),
        .out_free_count   (rsp.free_count)
    );

endmodule

// File: rtl/ffea_checker.sv
module ffea_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [ffea_pkg::STATUS_W-1:0]     rsp_status,
    input logic [ffea_pkg::SLOTF_W-1:0]      rsp_slot_index,
    input logic [ffea_pkg::START_W-1:0]      rsp_ext_base,
    input logic [ffea_pkg::TOT_W-1:0]        rsp_ext_len
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_ext_len))
        else $error("result dropped or changed under stall");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ffea_pkg::ST_OK |-> rsp_ext_len != '0)
        else $error("ok result with empty extent");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ffea_pkg::ST_NO_SPACE
            || rsp_status == ffea_pkg::ST_NO_SLOT || rsp_status == ffea_pkg::ST_NO_RUN)
        |-> rsp_slot_index == '0 && rsp_ext_base == '0 && rsp_ext_len == '0)
        else $error("allocate error with nonzero fields");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ffea_pkg::ST_SLOT_UNUSED
        |-> rsp_ext_base == '0 && rsp_ext_len == '0)
        else $error("unused slot free with nonzero extent");

endmodule

bind first_fit_extent_allocator_core ffea_checker u_ffea_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_index (rsp.slot_index),
    .rsp_ext_base   (rsp.extent_base),
    .rsp_ext_len    (rsp.extent_len)
);

// File: sim/first_fit_extent_allocator_core_tb.sv
`timescale 1ns / 1ps

module first_fit_extent_allocator_core_tb;

    typedef struct {
        logic [ffea_pkg::STATUS_W-1:0] status;
        logic [ffea_pkg::SLOTF_W-1:0]  slot_index;
        logic [ffea_pkg::START_W-1:0]  extent_base;
        logic [ffea_pkg::TOT_W-1:0]    extent_len;
        logic [ffea_pkg::TOT_W-1:0]    free_count;
    } extent_result_t;

    class extent_scoreboard;
        int unsigned    total;
        int unsigned    free_blk;
        bit             used [ffea_pkg::SLOTS];
        int unsigned    ext_start [ffea_pkg::SLOTS];
        int unsigned    ext_len [ffea_pkg::SLOTS];
        extent_result_t awaited [$];
        int             errors;

        function void reset_state();
            total    = ffea_pkg::TOTAL_RESET;
            free_blk = ffea_pkg::TOTAL_RESET;
            errors   = 0;
            for (int i = 0; i < ffea_pkg::SLOTS; i++)
            begin
                used[i]      = 0;
                ext_start[i] = 0;
                ext_len[i]   = 0;
            end
        endfunction

        function void set_total(logic [ffea_pkg::TOT_W-1:0] v);
            int unsigned t;
            t = 32'(v);
            if (t == 0)
                t = 1;
            if (t > ffea_pkg::TOTAL_MAX)
                t = ffea_pkg::TOTAL_MAX;
            total    = t;
            free_blk = t;
        endfunction

        function bit find_run(longint unsigned need, output longint unsigned st);
            longint unsigned cand;
            bit moved;
            cand  = 0;
            moved = 1;
            st    = 0;
            while (moved)
            begin
                moved = 0;
                if (cand + need > total)
                    return 0;
                for (int i = 0; i < ffea_pkg::SLOTS; i++)
                begin
                    if (used[i] && ext_start[i] < cand + need
                        && longint'(ext_start[i]) + ext_len[i] > cand)
                    begin
                        cand  = longint'(ext_start[i]) + ext_len[i];
                        moved = 1;
                        break;
                    end
                end
            end
            st = cand;
            return 1;
        endfunction

        function void note_request(logic op, logic [ffea_pkg::BYTES_W-1:0] bytes,
                                   logic [ffea_pkg::SLOTF_W-1:0] slot);
            extent_result_t  r;
            longint unsigned need;
            longint unsigned st;
            longint unsigned nf;
            int              idx;
            r = '{ffea_pkg::ST_OK, 0, 0, 0, 0};
            if (op)
            begin
                if (slot >= ffea_pkg::SLOTS || !used[slot])
                begin
                    r.status     = ffea_pkg::ST_SLOT_UNUSED;
                    r.slot_index = slot;
                end
                else
                begin
                    nf = longint'(free_blk) + ext_len[slot];
                    if (nf > total)
                        nf = total;
                    free_blk        = 32'(nf);
                    r.slot_index    = slot;
                    r.extent_base   = ffea_pkg::START_W'(ext_start[slot]);
                    r.extent_len    = ffea_pkg::TOT_W'(ext_len[slot]);
                    used[slot]      = 0;
                    ext_start[slot] = 0;
                    ext_len[slot]   = 0;
                end
            end
            else
            begin
                need = (longint'(bytes) + ffea_pkg::BLOCK_BYTES - 1) / ffea_pkg::BLOCK_BYTES;
                if (need == 0)
                    need = 1;
                idx = -1;
                for (int i = 0; i < ffea_pkg::SLOTS; i++)
                begin
                    if (!used[i])
                    begin
                        idx = i;
                        break;
                    end
                end
                if (need > free_blk)
                    r.status = ffea_pkg::ST_NO_SPACE;
                else if (idx < 0)
                    r.status = ffea_pkg::ST_NO_SLOT;
                else if (!find_run(need, st))
                    r.status = ffea_pkg::ST_NO_RUN;
                else
                begin
                    used[idx]      = 1;
                    ext_start[idx] = 32'(st);
                    ext_len[idx]   = 32'(need);
                    free_blk       = 32'(free_blk - need);
                    r.slot_index   = ffea_pkg::SLOTF_W'(idx);
                    r.extent_base  = ffea_pkg::START_W'(st);
                    r.extent_len   = ffea_pkg::TOT_W'(need);
                end
            end
            r.free_count = ffea_pkg::TOT_W'(free_blk);
            awaited.push_back(r);
        endfunction

        function void check_result(extent_result_t got);
            extent_result_t e;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: status %0d slot %0d start %0d",
                             got.status, got.slot_index, got.extent_base);
                return;
            end
            e = awaited.pop_front();
            if (got.status !== e.status || got.slot_index !== e.slot_index
                || got.extent_base !== e.extent_base || got.extent_len !== e.extent_len
                || got.free_count !== e.free_count)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp st %0d sl %0d sb %0d bc %0d fc %0d",
                              " / got st %0d sl %0d sb %0d bc %0d fc %0d"},
                             e.status, e.slot_index, e.extent_base, e.extent_len,
                             e.free_count, got.status, got.slot_index, got.extent_base,
                             got.extent_len, got.free_count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ffea_pkg::TOT_W-1:0] cfg_wdata;
    int   gap_pct;
    int   stall_pct;

    ffea_in_if  req_if ();
    ffea_out_if rsp_if ();

    extent_scoreboard sb;

    first_fit_extent_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if.sink),
        .rsp       (rsp_if.source)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #1000ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        extent_result_t got;
        if (rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.operation, req_if.request_bytes, req_if.slot);
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.status      = rsp_if.status;
            got.slot_index  = rsp_if.slot_index;
            got.extent_base = rsp_if.extent_base;
            got.extent_len  = rsp_if.extent_len;
            got.free_count  = rsp_if.free_count;
            sb.check_result(got);
        end
    end

    task automatic send(logic op, logic [ffea_pkg::BYTES_W-1:0] bytes,
                        logic [ffea_pkg::SLOTF_W-1:0] slot);
        if ($urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.request_bytes <= bytes;
        req_if.slot          <= slot;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_total(logic [ffea_pkg::TOT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_total(v);
    endtask

    task automatic random_item();
        int unsigned pick;
        int          busy [$];
        logic [ffea_pkg::BYTES_W-1:0] bytes;
        if ($urandom_range(99) < 40)
        begin
            for (int i = 0; i < ffea_pkg::SLOTS; i++)
                if (sb.used[i])
                    busy.push_back(i);
            if (busy.size() != 0 && $urandom_range(99) < 75)
                send(1'b1, $urandom(),
                     ffea_pkg::SLOTF_W'(busy[$urandom_range(busy.size() - 1)]));
            else
                send(1'b1, $urandom(), ffea_pkg::SLOTF_W'($urandom_range(63)));
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                bytes = $urandom();
            else if (pick == 1)
                bytes = 0;
            else if (pick == 2)
                bytes = $urandom_range(0, 32'h07FF_FFFF);
            else
                bytes = $urandom_range(0, 24 * ffea_pkg::BLOCK_BYTES);
            send(1'b0, bytes, ffea_pkg::SLOTF_W'($urandom_range(63)));
        end
    endtask

    initial
    begin
        int unsigned totals [8];
        int          err;
        totals = '{131072, 64, 200, 1, 1048576, 500, 2048, 100};
        sb = new();
        sb.reset_state();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.operation     = 1'b0;
        req_if.request_bytes = '0;
        req_if.slot          = '0;
        rsp_if.ready         = 1'b0;
        gap_pct              = 0;
        stall_pct            = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b0, 32'd0, 6'd0);
        send(1'b0, 32'd1, 6'd0);
        send(1'b0, 32'd4096, 6'd0);
        send(1'b0, 32'd4097, 6'd63);
        send(1'b0, 32'hFFFF_FFFF, 6'd0);
        send(1'b1, 32'hFFFF_FFFF, 6'd63);
        send(1'b1, 32'd0, 6'd1);
        send(1'b1, 32'd0, 6'd1);
        drain();
        write_total(21'd0);
        send(1'b0, 32'd1, 6'd0);
        send(1'b0, 32'd1, 6'd0);
        drain();
        write_total(21'h1F_FFFF);
        send(1'b0, 32'hFFFF_FFFF, 6'd0);
        send(1'b1, 32'd0, 6'd0);
        send(1'b1, 32'd0, 6'd2);
        send(1'b1, 32'd0, 6'd3);
        send(1'b0, 32'hFFFF_FFFF, 6'd0);
        send(1'b1, 32'd0, 6'd0);
        drain();
        write_total(21'd3);
        send(1'b0, 32'd8192, 6'd0);
        send(1'b0, 32'd8193, 6'd0);
        send(1'b0, 32'd1, 6'd0);
        send(1'b0, 32'd1, 6'd0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_total(ffea_pkg::TOT_W'(totals[ph]));
            gap_pct   = (ph % 4 == 1) ? 68 : (ph % 4 == 3) ? 17 : 0;
            stall_pct = (ph % 4 == 2) ? 68 : (ph % 4 == 3) ? 17 : 0;
            for (int n = 0; n < 240; n++)
                random_item();
            drain();
        end

        err = sb.errors + sb.awaited.size();
        if (err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
